// ===== rtl/dwg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dwg_pkg;

  // Default grid side and fixed field widths
  localparam int GRID_MAX_DEF = 64;
  localparam int SZ_W         = 7;
  localparam int CELL_W       = 6;
  localparam int VAL_W        = 32;
  localparam int FRAC_W       = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 31;
  localparam int ACC_W        = 64;

  // Command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_IMPULSE = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_ENDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_RETAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_RETAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMPULSE_LIMIT = 3'd6;

  localparam logic signed [ACC_W-1:0] MAX32 = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] MIN32 = -64'sd2147483648;

  // Saturate a wide value to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > MAX32) begin
      r = MAX32[VAL_W-1:0];
    end else if (v < MIN32) begin
      r = MIN32[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dwg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/damped_wave_grid_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   cmd, cell_x, cell_y, amount, frac_x, frac_y
// out       source     out_valid/out_stall height_value, status
// cfg       sink       cfg_we              cfg_index, cfg_data
//
// After reset a clearing pass writes zero to all GRID_MAX*GRID_MAX cells (4096 at
// the default) of all three grids, and in_stall stays high until it ends.
// A tick runs a force pass over every cell and then an integration pass, paced
// by the single read port of the height RAM and the one shared 36x18 multiplier.
// One item is worked at a time; in_stall is high while it runs. A result waits
// in the output register while the next request is taken.

module damped_wave_grid_engine #(
  parameter int GRID_MAX = dwg_pkg::GRID_MAX_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           cmd,
  input  wire logic [dwg_pkg::CELL_W-1:0]           cell_x,
  input  wire logic [dwg_pkg::CELL_W-1:0]           cell_y,
  input  wire logic signed [dwg_pkg::VAL_W-1:0]     amount,
  input  wire logic [dwg_pkg::FRAC_W-1:0]           frac_x,
  input  wire logic [dwg_pkg::FRAC_W-1:0]           frac_y,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [dwg_pkg::VAL_W-1:0]          height_value,
  output logic                                      status,
  input  wire logic                                 cfg_we,
  input  wire logic [dwg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dwg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import dwg_pkg::*;

  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(CELLS);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_FORCE   = 4'd2;
  localparam logic [3:0] ST_INTEG   = 4'd3;
  localparam logic [3:0] ST_IMPULSE = 4'd4;
  localparam logic [3:0] ST_MOD     = 4'd5;
  localparam logic [3:0] ST_SAMPLE  = 4'd6;
  localparam logic [3:0] ST_FINISH  = 4'd7;

  // Configuration registers
  logic [SZ_W-1:0] grid_size;
  logic            closed_ends;
  logic [23:0]     spring_gain;
  logic [15:0]     time_step;
  logic [16:0]     pos_retain;
  logic [16:0]     vel_retain;
  logic [30:0]     impulse_limit;

  // Sequencer state
  logic [3:0]             state;
  logic [3:0]             step;
  logic [AW-1:0]          clr_addr;
  logic [SZ_W-1:0]        x;
  logic [SZ_W-1:0]        y;
  logic [CELL_W-1:0]      sx;
  logic [CELL_W-1:0]      sy;
  logic signed [VAL_W-1:0] amt;
  logic [FRAC_W-1:0]      fx;
  logic [FRAC_W-1:0]      fy;

  // Datapath registers
  logic signed [35:0]      lap;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum;
  logic signed [VAL_W-1:0] hreg;
  logic signed [VAL_W-1:0] vreg;
  logic signed [VAL_W-1:0] dreg;
  logic signed [32:0]      dcreg;
  logic signed [VAL_W-1:0] res;
  logic                    stat;

  logic [SZ_W-1:0] n;
  logic            accept;
  logic [SZ_W-1:0] x0, x2, y0, y2, xw, yw;
  logic            border;
  logic [AW-1:0]   cur_addr;
  logic [AW-1:0]   h_raddr;
  logic [AW-1:0]   waddr;
  logic            h_we, v_we, p_we;
  logic signed [VAL_W-1:0] h_wdata, v_wdata, p_wdata;
  logic signed [VAL_W-1:0] h_rd, v_rd, p_rd;
  logic signed [35:0]      mul_a;
  logic signed [17:0]      mul_b;
  logic signed [53:0]      prod;
  logic signed [ACC_W-1:0] prod64;
  logic signed [ACC_W-1:0] acc_sh;
  logic [17:0]             fxc, fyc;
  logic signed [32:0]      d33, lim33, dc;
  logic signed [VAL_W-1:0] hz, vz;
  logic [SZ_W:0]           tx, ty;
  logic [SZ_W-1:0]         mod_x, mod_y;

  function automatic logic [AW-1:0] addr_of(input logic [SZ_W-1:0] cx,
                                             input logic [SZ_W-1:0] cy);
    return AW'(32'(cx) * GRID_MAX + 32'(cy));
  endfunction

  assign n = (32'(grid_size) > GRID_MAX) ? SZ_W'(GRID_MAX) : grid_size;
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;

  // Neighbour coordinates for the Laplacian and for bilinear wrap
  assign x0 = (x == '0) ? (closed_ends ? '0 : n - 1'b1) : x - 1'b1;
  assign y0 = (y == '0) ? (closed_ends ? '0 : n - 1'b1) : y - 1'b1;
  assign x2 = (x == n - 1'b1) ? (closed_ends ? n - 1'b1 : '0) : x + 1'b1;
  assign y2 = (y == n - 1'b1) ? (closed_ends ? n - 1'b1 : '0) : y + 1'b1;
  assign xw = (x + 1'b1 == n) ? '0 : x + 1'b1;
  assign yw = (y + 1'b1 == n) ? '0 : y + 1'b1;
  assign border = closed_ends &&
                  ((x == '0) || (y == '0) || (x == n - 1'b1) || (y == n - 1'b1));
  assign cur_addr = addr_of(x, y);

  // Remainder step: shift one coordinate bit in, subtract size when it fits
  assign tx = {x, sx[CELL_W-1]};
  assign ty = {y, sy[CELL_W-1]};
  assign mod_x = (tx >= {1'b0, n}) ? SZ_W'(tx - {1'b0, n}) : tx[SZ_W-1:0];
  assign mod_y = (ty >= {1'b0, n}) ? SZ_W'(ty - {1'b0, n}) : ty[SZ_W-1:0];

  // Impulse clamp against the limit
  assign d33   = {p_rd[VAL_W-1], p_rd};
  assign lim33 = {2'b00, impulse_limit};
  assign dc    = (d33 > lim33) ? lim33 : ((d33 < -lim33) ? -lim33 : d33);
  assign hz    = border ? '0 : h_rd;
  assign vz    = border ? '0 : v_rd;

  assign fxc = 18'h10000 - {2'b00, fx};
  assign fyc = 18'h10000 - {2'b00, fy};

  // Select height read address per step
  always_comb begin
    h_raddr = cur_addr;
    case (state)
      ST_FORCE: begin
        case (step)
          4'd0:    h_raddr = addr_of(x0, y);
          4'd1:    h_raddr = addr_of(x, y0);
          4'd2:    h_raddr = addr_of(x, y2);
          4'd3:    h_raddr = addr_of(x2, y);
          default: h_raddr = cur_addr;
        endcase
      end
      ST_SAMPLE: begin
        case (step)
          4'd1:    h_raddr = addr_of(xw, y);
          4'd2:    h_raddr = addr_of(x, yw);
          4'd3:    h_raddr = addr_of(xw, yw);
          default: h_raddr = cur_addr;
        endcase
      end
      default: h_raddr = cur_addr;
    endcase
  end

  // Select shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_FORCE: begin
        mul_a = lap;
        mul_b = (step == 4'd6) ? {6'd0, spring_gain[11:0]} : {6'd0, spring_gain[23:12]};
      end
      ST_INTEG: begin
        case (step)
          4'd1: begin
            mul_a = {{4{hz[VAL_W-1]}}, hz};
            mul_b = {1'b0, pos_retain};
          end
          4'd2: begin
            mul_a = {{4{vreg[VAL_W-1]}}, vreg};
            mul_b = {2'b00, time_step};
          end
          default: begin
            mul_a = {{4{vreg[VAL_W-1]}}, vreg};
            mul_b = {1'b0, vel_retain};
          end
        endcase
      end
      ST_SAMPLE: begin
        case (step)
          4'd1, 4'd3: begin
            mul_a = {{4{h_rd[VAL_W-1]}}, h_rd};
            mul_b = fxc;
          end
          4'd2, 4'd4: begin
            mul_a = {{4{h_rd[VAL_W-1]}}, h_rd};
            mul_b = {2'b00, fx};
          end
          4'd5: begin
            mul_a = {{4{hreg[VAL_W-1]}}, hreg};
            mul_b = fyc;
          end
          default: begin
            mul_a = {{4{vreg[VAL_W-1]}}, vreg};
            mul_b = {2'b00, fy};
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod64 = {{(ACC_W-54){prod[53]}}, prod};
  assign acc_sh = acc >>> 16;

  // Grid write ports
  always_comb begin
    h_we    = 1'b0;
    v_we    = 1'b0;
    p_we    = 1'b0;
    waddr   = cur_addr;
    h_wdata = '0;
    v_wdata = '0;
    p_wdata = '0;
    case (state)
      ST_CLEAR: begin
        h_we  = 1'b1;
        v_we  = 1'b1;
        p_we  = 1'b1;
        waddr = clr_addr;
      end
      ST_FORCE: begin
        v_we    = (step == 4'd8);
        v_wdata = sat32({{32{vreg[VAL_W-1]}}, vreg} + acc_sh);
      end
      ST_INTEG: begin
        h_we    = (step == 4'd4);
        v_we    = (step == 4'd4);
        p_we    = (step == 4'd4);
        h_wdata = sat32(sum);
        v_wdata = sat32(acc_sh);
        p_wdata = sat32({{32{dreg[VAL_W-1]}}, dreg} - {{31{dcreg[32]}}, dcreg});
      end
      ST_IMPULSE: begin
        p_we    = (step == 4'd1);
        p_wdata = sat32({{32{p_rd[VAL_W-1]}}, p_rd} + {{32{amt[VAL_W-1]}}, amt});
      end
      default: begin
        h_we = 1'b0;
      end
    endcase
  end

  dwg_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_height (
    .clk(clk), .we(h_we), .waddr(waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rd)
  );

  dwg_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_velocity (
    .clk(clk), .we(v_we), .waddr(waddr), .wdata(v_wdata), .raddr(cur_addr), .rdata(v_rd)
  );

  dwg_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_pending (
    .clk(clk), .we(p_we), .waddr(waddr), .wdata(p_wdata), .raddr(cur_addr), .rdata(p_rd)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= 7'd32;
      closed_ends   <= 1'b1;
      spring_gain   <= '0;
      time_step     <= '0;
      pos_retain    <= 17'h10000;
      vel_retain    <= 17'h10000;
      impulse_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIZE:     grid_size     <= cfg_data[SZ_W-1:0];
        REG_CLOSED_ENDS:   closed_ends   <= cfg_data[0];
        REG_SPRING_GAIN:   spring_gain   <= cfg_data[23:0];
        REG_TIME_STEP:     time_step     <= cfg_data[15:0];
        REG_POS_RETAIN:    pos_retain    <= cfg_data[16:0];
        REG_VEL_RETAIN:    vel_retain    <= cfg_data[16:0];
        REG_IMPULSE_LIMIT: impulse_limit <= cfg_data[30:0];
        default:           grid_size     <= grid_size;
      endcase
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            amt  <= amount;
            fx   <= frac_x;
            fy   <= frac_y;
            sx   <= cell_x;
            sy   <= cell_y;
            res  <= '0;
            stat <= 1'b0;
            step <= '0;
            case (cmd)
              CMD_TICK: begin
                x <= '0;
                y <= '0;
                state <= (n == '0) ? ST_FINISH : ST_FORCE;
              end
              CMD_IMPULSE: begin
                x <= {1'b0, cell_x};
                y <= {1'b0, cell_y};
                if (({1'b0, cell_x} >= n) || ({1'b0, cell_y} >= n)) begin
                  stat  <= 1'b1;
                  state <= ST_FINISH;
                end else begin
                  state <= ST_IMPULSE;
                end
              end
              CMD_SAMPLE: begin
                x <= '0;
                y <= '0;
                state <= (n == '0) ? ST_FINISH : ST_MOD;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_FORCE: begin
          step <= step + 1'b1;
          case (step)
            4'd1: begin
              lap  <= {{4{h_rd[VAL_W-1]}}, h_rd};
              vreg <= v_rd;
            end
            4'd2, 4'd3, 4'd4: lap <= lap + {{4{h_rd[VAL_W-1]}}, h_rd};
            4'd5: lap <= lap - {{2{h_rd[VAL_W-1]}}, h_rd, 2'b00};
            4'd6: acc <= prod64;
            4'd7: acc <= acc + (prod64 <<< 12);
            4'd8: begin
              // Advance to the next cell, then to the integration pass
              step <= '0;
              if (y == n - 1'b1) begin
                y <= '0;
                if (x == n - 1'b1) begin
                  x <= '0;
                  state <= ST_INTEG;
                end else begin
                  x <= x + 1'b1;
                end
              end else begin
                y <= y + 1'b1;
              end
            end
            default: lap <= lap;
          endcase
        end
        ST_INTEG: begin
          step <= step + 1'b1;
          case (step)
            4'd1: begin
              vreg  <= vz;
              dreg  <= p_rd;
              dcreg <= dc;
              acc   <= prod64;
            end
            4'd2: begin
              sum <= acc_sh + {{31{dcreg[32]}}, dcreg};
              acc <= prod64;
            end
            4'd3: begin
              sum <= sum + acc_sh;
              acc <= prod64;
            end
            4'd4: begin
              step <= '0;
              if (y == n - 1'b1) begin
                y <= '0;
                if (x == n - 1'b1) begin
                  x <= '0;
                  state <= ST_FINISH;
                end else begin
                  x <= x + 1'b1;
                end
              end else begin
                y <= y + 1'b1;
              end
            end
            default: sum <= sum;
          endcase
        end
        ST_IMPULSE: begin
          step <= step + 1'b1;
          if (step == 4'd1) begin
            state <= ST_FINISH;
          end
        end
        ST_MOD: begin
          x    <= mod_x;
          y    <= mod_y;
          sx   <= sx << 1;
          sy   <= sy << 1;
          step <= step + 1'b1;
          if (step == 4'(CELL_W - 1)) begin
            step  <= '0;
            state <= ST_SAMPLE;
          end
        end
        ST_SAMPLE: begin
          step <= step + 1'b1;
          case (step)
            4'd1: acc <= prod64;
            4'd2: acc <= acc + prod64;
            4'd3: begin
              hreg <= acc_sh[VAL_W-1:0];
              acc  <= prod64;
            end
            4'd4: acc <= acc + prod64;
            4'd5: begin
              vreg <= acc_sh[VAL_W-1:0];
              acc  <= prod64;
            end
            4'd6: acc <= acc + prod64;
            4'd7: begin
              res   <= sat32(acc_sh);
              state <= ST_FINISH;
            end
            default: acc <= acc;
          endcase
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            height_value <= res;
            status       <= stat;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
